@@ rtl/core/aapo_pkg.sv @@
// ----------------------------------------------------------------------------
// aapo_pkg: shared definitions for the all-pairs box overlap block
// Store geometry, coordinate width, command codes and sequencer states.
// ----------------------------------------------------------------------------
package aapo_pkg;

  // Capacity of the body store and coordinate width as the host supplies it.
  localparam int MAX_BODIES  = 32;
  localparam int COORD_WIDTH = 32;

  // Widths fixed by the interface fields.
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int RUN_W   = 5;
  localparam int TOTAL_W = 9;
  localparam int PORT_W  = 32;

  // Derived sizes.
  localparam int STORE_AW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW        = (COORD_WIDTH < PORT_W) ? COORD_WIDTH : PORT_W;
  localparam int LIMIT_CAP = (MAX_BODIES < (1 << IDX_W)) ? MAX_BODIES : (1 << IDX_W);

  localparam logic [CNT_W-1:0]   LIMIT_MAX = CNT_W'(LIMIT_CAP);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Command codes carried on func.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // One stored body: enabled flag and both corners.
  typedef struct packed {
    logic                 en;
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] hi_z;
  } body_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_TERM
  } aapo_state_t;

endpackage

@@ rtl/core/aabb_all_pairs_overlap_top.sv @@
// ----------------------------------------------------------------------------
// aabb_all_pairs_overlap_top: brute-force box overlap broad phase
// Stores body boxes and scans one body against all later bodies.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken on a rising edge where start is high and
// busy is low. func selects a load (write one box into the store at
// body_index; never gives a result and leaves busy low) or a scan
// (compare body_index against every later body below the body count). The
// body count register is written through its own channel (cfg_valid/cfg_ready/
// cfg_data), and cfg_ready is high whenever busy is low.
//
// A scan first fetches the scanned body and then compares one stored body
// per cycle through a single six-way comparator bank, fed by the store's
// registered read port. Every overlapping pair comes out as one result beat,
// marked by result_strobe for exactly one cycle, and the scan ends with a
// terminator beat (last high) carrying the pair count of the scan and the
// running total. A scan of a disabled body, or of a body at or past the
// limit, compares no body. The terminator beat appears at the same edge at
// which busy falls. The receiver cannot stall: beats are taken as shown.
//
// Reset clears the sequencer, the body count and the running total. The
// store itself is not cleared; a body must be loaded before it is scanned.
// ----------------------------------------------------------------------------
module aabb_all_pairs_overlap_top (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [aapo_pkg::IDX_W-1:0]     body_index,
  input  logic                           enabled,
  input  logic signed [aapo_pkg::PORT_W-1:0] min_x,
  input  logic signed [aapo_pkg::PORT_W-1:0] min_y,
  input  logic signed [aapo_pkg::PORT_W-1:0] min_z,
  input  logic signed [aapo_pkg::PORT_W-1:0] max_x,
  input  logic signed [aapo_pkg::PORT_W-1:0] max_y,
  input  logic signed [aapo_pkg::PORT_W-1:0] max_z,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aapo_pkg::CNT_W-1:0]     cfg_data,
  // result channel
  output logic                           result_strobe,
  output logic                           pair_valid,
  output logic [aapo_pkg::IDX_W-1:0]     first_index,
  output logic [aapo_pkg::IDX_W-1:0]     second_index,
  output logic                           last,
  output logic [aapo_pkg::RUN_W-1:0]     run_pairs,
  output logic [aapo_pkg::TOTAL_W-1:0]   total_pairs
);

  localparam int AW = aapo_pkg::STORE_AW;

  // Body store: one write port for loads, one registered read port that the
  // sequencer steers to the scanned body and then to each later body.
  aapo_pkg::body_t mem [aapo_pkg::MAX_BODIES];
  aapo_pkg::body_t rdata;
  aapo_pkg::body_t wentry;
  logic [AW-1:0]   rd_addr;
  logic            we;

  // Sequencer state.
  aapo_pkg::aapo_state_t state, state_next;
  logic [aapo_pkg::IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [aapo_pkg::CNT_W-1:0]   limit, limit_next;
  logic [aapo_pkg::CNT_W-1:0]   cmp_idx, cmp_idx_next;
  logic [aapo_pkg::RUN_W-1:0]   run, run_next;
  logic [aapo_pkg::TOTAL_W-1:0] total, total_next;
  logic [aapo_pkg::CNT_W-1:0]   count;
  aapo_pkg::body_t              body_a, body_a_next;

  // Result beat being prepared for the output register.
  logic                         emit;
  logic                         emit_pair;
  logic [aapo_pkg::IDX_W-1:0]   emit_second;

  logic                         accept;
  logic [aapo_pkg::CNT_W-1:0]   lim_now;
  logic [aapo_pkg::CNT_W-1:0]   cmp_inc;
  logic [aapo_pkg::CNT_W-1:0]   first_j;
  logic [aapo_pkg::TOTAL_W-1:0] total_base;
  logic [aapo_pkg::TOTAL_W:0]   total_sum;
  logic                         hit;

  assign busy      = (state != aapo_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Scans stop at the body count, clamped to the store capacity.
  assign lim_now = (count > aapo_pkg::LIMIT_MAX) ? aapo_pkg::LIMIT_MAX : count;

  assign cmp_inc = cmp_idx + 1'b1;
  assign first_j = {1'b0, scan_idx} + 1'b1;

  // The comparator bank: inclusive overlap on all three axes, and the
  // compared body must take part. The scanned body was checked at fetch.
  always_comb begin
    hit = rdata.en
       && ($signed(body_a.hi_x) >= $signed(rdata.lo_x))
       && ($signed(rdata.hi_x)  >= $signed(body_a.lo_x))
       && ($signed(body_a.hi_y) >= $signed(rdata.lo_y))
       && ($signed(rdata.hi_y)  >= $signed(body_a.lo_y))
       && ($signed(body_a.hi_z) >= $signed(rdata.lo_z))
       && ($signed(rdata.hi_z)  >= $signed(body_a.lo_z));
  end

  // Scanning body zero restarts the running total; the sum saturates.
  assign total_base = (scan_idx == '0) ? '0 : total;
  assign total_sum  = {1'b0, total_base} + (aapo_pkg::TOTAL_W + 1)'(run);

  // Load beats keep only the low coordinate bits, read back as signed.
  always_comb begin
    wentry.en   = enabled;
    wentry.lo_x = min_x[aapo_pkg::CW-1:0];
    wentry.lo_y = min_y[aapo_pkg::CW-1:0];
    wentry.lo_z = min_z[aapo_pkg::CW-1:0];
    wentry.hi_x = max_x[aapo_pkg::CW-1:0];
    wentry.hi_y = max_y[aapo_pkg::CW-1:0];
    wentry.hi_z = max_z[aapo_pkg::CW-1:0];
  end

  assign we = accept && (func == aapo_pkg::FUNC_LOAD)
           && (32'(body_index) < aapo_pkg::MAX_BODIES);

  // Next state, read address and result beat.
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    limit_next    = limit;
    cmp_idx_next  = cmp_idx;
    run_next      = run;
    total_next    = total;
    body_a_next   = body_a;
    rd_addr       = AW'(body_index);
    emit          = 1'b0;
    emit_pair     = 1'b0;
    emit_second   = '0;

    unique case (state)
      aapo_pkg::ST_IDLE: begin
        if (accept && (func == aapo_pkg::FUNC_SCAN)) begin
          scan_idx_next = body_index;
          limit_next    = lim_now;
          run_next      = '0;
          if ({1'b0, body_index} < lim_now) begin
            state_next = aapo_pkg::ST_FETCH;
          end else begin
            state_next = aapo_pkg::ST_TERM;
          end
        end
      end
      aapo_pkg::ST_FETCH: begin
        // Read data is the scanned body; start reading the next one.
        body_a_next  = rdata;
        cmp_idx_next = first_j;
        rd_addr      = AW'(first_j);
        if (rdata.en && (first_j < limit)) begin
          state_next = aapo_pkg::ST_SCAN;
        end else begin
          state_next = aapo_pkg::ST_TERM;
        end
      end
      aapo_pkg::ST_SCAN: begin
        if (hit) begin
          emit        = 1'b1;
          emit_pair   = 1'b1;
          emit_second = aapo_pkg::IDX_W'(cmp_idx);
          run_next    = run + 1'b1;
        end
        cmp_idx_next = cmp_inc;
        rd_addr      = AW'(cmp_inc);
        if (cmp_inc >= limit) begin
          state_next = aapo_pkg::ST_TERM;
        end
      end
      aapo_pkg::ST_TERM: begin
        total_next = (total_sum > {1'b0, aapo_pkg::TOTAL_MAX})
                   ? aapo_pkg::TOTAL_MAX : aapo_pkg::TOTAL_W'(total_sum);
        emit       = 1'b1;
        state_next = aapo_pkg::ST_IDLE;
      end
      default: begin
        state_next = aapo_pkg::ST_IDLE;
      end
    endcase
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(body_index)] <= wentry;
    end
    rdata <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= aapo_pkg::ST_IDLE;
      total         <= '0;
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      total         <= total_next;
      result_strobe <= emit;
      if (cfg_valid && cfg_ready) begin
        count <= cfg_data;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    limit    <= limit_next;
    cmp_idx  <= cmp_idx_next;
    run      <= run_next;
    body_a   <= body_a_next;
    if (emit) begin
      pair_valid   <= emit_pair;
      first_index  <= scan_idx;
      second_index <= emit_second;
      last         <= !emit_pair;
      run_pairs    <= emit_pair ? '0 : run;
      total_pairs  <= emit_pair ? '0 : total_next;
    end
  end

endmodule

@@ rtl/core/aapo_checker.sv @@
// ----------------------------------------------------------------------------
// aapo_checker: port-level checks for the box overlap block
// Watches command, busy and result beats and is bound to the top level.
// ----------------------------------------------------------------------------
module aapo_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         func,
  input logic                         result_strobe,
  input logic                         pair_valid,
  input logic [aapo_pkg::IDX_W-1:0]   first_index,
  input logic [aapo_pkg::IDX_W-1:0]   second_index,
  input logic                         last
);

  // A scan command always holds the block busy in the next cycle.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == aapo_pkg::FUNC_SCAN)) |=> busy)
    else $error("scan beat did not make the block busy");

  // Every scan ends with its terminator right after busy falls.
  a_term_on_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_strobe && last && !pair_valid))
    else $error("busy fell without a terminator beat");

  // Pair beats only come while the scan is still running.
  a_pair_in_scan: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && pair_valid) |-> (busy && !last))
    else $error("pair beat outside a running scan");

  // A pair always names a later body than the scanned one.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && pair_valid) |-> (second_index > first_index))
    else $error("pair beat with second index not above first");

endmodule

bind aabb_all_pairs_overlap_top aapo_checker u_aapo_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .func          (func),
  .result_strobe (result_strobe),
  .pair_valid    (pair_valid),
  .first_index   (first_index),
  .second_index  (second_index),
  .last          (last)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for aabb_all_pairs_overlap_top
// Loads body boxes, writes the body count between phases and scans bodies,
// predicting every pair beat and terminator beat and comparing them in order.
// ----------------------------------------------------------------------------
module testbench;

  // Q16.16 scale and the coordinate extremes.
  localparam int UNIT_Q16   = 1 << 16;
  localparam int COORD_LOW  = 32'sh8000_0000;
  localparam int COORD_HIGH = 32'sh7fff_ffff;

  // Cycles with nothing moving on any channel before the run is declared hung.
  // The limit is many times the longest honest silence, which a scan, a sender
  // gap or a phase break can give.
  localparam int HANG_LIMIT = 3000;

  // Quiet time that settle() waits for; any scan drains well within it.
  localparam int SETTLE_CYCLES = 40;

  localparam int SHOW_LIMIT = 10;

  // One command beat as the host presents it.
  typedef struct packed {
    logic                             func;
    logic [aapo_pkg::IDX_W-1:0]       idx;
    logic                             en;
    logic [2:0][aapo_pkg::PORT_W-1:0] lo;
    logic [2:0][aapo_pkg::PORT_W-1:0] hi;
  } command_t;

  // One result beat: a pair or a scan terminator.
  typedef struct packed {
    logic                         pair_valid;
    logic [aapo_pkg::IDX_W-1:0]   first;
    logic [aapo_pkg::IDX_W-1:0]   second;
    logic                         last;
    logic [aapo_pkg::RUN_W-1:0]   run;
    logic [aapo_pkg::TOTAL_W-1:0] total;
  } pair_beat_t;

  // The predictor's copy of one stored body, corners already narrowed.
  typedef struct {
    bit     en;
    longint lo [3];
    longint hi [3];
  } shadow_body_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               start      = 1'b0;
  logic                               func       = aapo_pkg::FUNC_LOAD;
  logic [aapo_pkg::IDX_W-1:0]         body_index = '0;
  logic                               enabled    = 1'b0;
  logic signed [aapo_pkg::PORT_W-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic signed [aapo_pkg::PORT_W-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic                               cfg_valid  = 1'b0;
  logic [aapo_pkg::CNT_W-1:0]         cfg_data   = '0;

  logic                               busy;
  logic                               cfg_ready;
  logic                               result_strobe;
  logic                               pair_valid;
  logic [aapo_pkg::IDX_W-1:0]         first_index;
  logic [aapo_pkg::IDX_W-1:0]         second_index;
  logic                               last;
  logic [aapo_pkg::RUN_W-1:0]         run_pairs;
  logic [aapo_pkg::TOTAL_W-1:0]       total_pairs;

  aabb_all_pairs_overlap_top uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .body_index    (body_index),
    .enabled       (enabled),
    .min_x         (min_x),
    .min_y         (min_y),
    .min_z         (min_z),
    .max_x         (max_x),
    .max_y         (max_y),
    .max_z         (max_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .pair_valid    (pair_valid),
    .first_index   (first_index),
    .second_index  (second_index),
    .last          (last),
    .run_pairs     (run_pairs),
    .total_pairs   (total_pairs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands not yet presented, and beats predicted but not yet seen.
  command_t   commands_waiting [$];
  pair_beat_t pair_beats_due [$];

  // Predictor state: the body store, the running total and the count register.
  shadow_body_t shadow_bodies [aapo_pkg::MAX_BODIES];
  int           shadow_total = 0;
  int           shadow_count = 0;

  command_t cur_cmd;
  int       gap_left = 0;
  bit       calm = 1'b0;
  int       errors = 0;
  int       shown = 0;
  int       hang_cycles = 0;

  // Applies one accepted command to the shadow store and queues the beats the
  // block must give for it. A load only updates the store. A scan compares
  // body i against every later body below the clamped count, inclusive on all
  // three axes, and always ends with a terminator beat.
  function automatic void broad_phase_step(command_t c);
    int         lim;
    int         run;
    int         i;
    bit         hit;
    pair_beat_t beat;
    i = int'(c.idx);
    if (c.func == aapo_pkg::FUNC_LOAD) begin
      if (i < aapo_pkg::MAX_BODIES) begin
        shadow_bodies[i].en = c.en;
        for (int k = 0; k < 3; k++) begin
          // Only the low CW bits of a corner are kept, sign extended.
          shadow_bodies[i].lo[k] = $signed(c.lo[k][aapo_pkg::CW-1:0]);
          shadow_bodies[i].hi[k] = $signed(c.hi[k][aapo_pkg::CW-1:0]);
        end
      end
      return;
    end
    lim = shadow_count;
    if (lim > aapo_pkg::MAX_BODIES) lim = aapo_pkg::MAX_BODIES;
    if (lim > (1 << aapo_pkg::IDX_W)) lim = 1 << aapo_pkg::IDX_W;
    // Scanning body zero restarts the running total, even with a zero count.
    if (i == 0) shadow_total = 0;
    run = 0;
    if (i < lim && shadow_bodies[i].en) begin
      for (int j = i + 1; j < lim; j++) begin
        if (!shadow_bodies[j].en) continue;
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (!(shadow_bodies[i].hi[k] >= shadow_bodies[j].lo[k] &&
                shadow_bodies[j].hi[k] >= shadow_bodies[i].lo[k])) hit = 1'b0;
        end
        if (hit) begin
          beat = '0;
          beat.pair_valid = 1'b1;
          beat.first = aapo_pkg::IDX_W'(i);
          beat.second = aapo_pkg::IDX_W'(j);
          pair_beats_due = {pair_beats_due, beat};
          run++;
        end
      end
    end
    shadow_total += run;
    if (shadow_total > int'(aapo_pkg::TOTAL_MAX)) shadow_total = int'(aapo_pkg::TOTAL_MAX);
    beat = '0;
    beat.first = aapo_pkg::IDX_W'(i);
    beat.last = 1'b1;
    beat.run = aapo_pkg::RUN_W'(run);
    beat.total = aapo_pkg::TOTAL_W'(shadow_total);
    pair_beats_due = {pair_beats_due, beat};
  endfunction

  // Driver. A presented command stays on the ports while busy holds it off.
  // Otherwise the next command is taken from the queue, unless a random idle
  // burst is running. The shadow model is updated at the very edge at which
  // the block takes a command or a count write.
  always @(posedge clk) begin
    logic drive_start;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_count = int'(cfg_data);
      if (start && !busy) broad_phase_step(cur_cmd);
      drive_start = start;
      if (!(start && busy)) begin
        drive_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (commands_waiting.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 9) - 1;
          end else begin
            cur_cmd = commands_waiting.pop_front();
            func       <= cur_cmd.func;
            body_index <= cur_cmd.idx;
            enabled    <= cur_cmd.en;
            min_x      <= cur_cmd.lo[0];
            min_y      <= cur_cmd.lo[1];
            min_z      <= cur_cmd.lo[2];
            max_x      <= cur_cmd.hi[0];
            max_y      <= cur_cmd.hi[1];
            max_z      <= cur_cmd.hi[2];
            drive_start = 1'b1;
          end
        end
      end
      start <= drive_start;
    end
  end

  task automatic report_mismatch(string what, pair_beat_t want, pair_beat_t seen);
    errors++;
    if (shown < SHOW_LIMIT) begin
      shown++;
      $display("%0t %s: expected pv=%0d i=%0d j=%0d last=%0d run=%0d total=%0d",
               $time, what, want.pair_valid, want.first, want.second, want.last,
               want.run, want.total);
      $display("%0t %s:   actual pv=%0d i=%0d j=%0d last=%0d run=%0d total=%0d",
               $time, what, seen.pair_valid, seen.first, seen.second, seen.last,
               seen.run, seen.total);
    end
  endtask

  // Monitor. The receiver cannot stall, so every strobed cycle is one beat
  // and is checked against the oldest prediction.
  always @(posedge clk) begin
    pair_beat_t seen;
    pair_beat_t want;
    if (!rst && result_strobe) begin
      seen = {pair_valid, first_index, second_index, last, run_pairs, total_pairs};
      if (pair_beats_due.size() == 0) begin
        report_mismatch("unexpected beat", '0, seen);
      end else begin
        want = pair_beats_due.pop_front();
        if (seen !== want) report_mismatch("beat mismatch", want, seen);
      end
    end
  end

  // Watchdog: any command, count write or result beat counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("aabb_all_pairs_overlap_top verification failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Stimulus helpers.
  task automatic push_load(int idx, bit en, int lx, int ly, int lz, int hx, int hy, int hz);
    command_t c;
    c.func = aapo_pkg::FUNC_LOAD;
    c.idx = aapo_pkg::IDX_W'(idx);
    c.en = en;
    c.lo = {aapo_pkg::PORT_W'(lz), aapo_pkg::PORT_W'(ly), aapo_pkg::PORT_W'(lx)};
    c.hi = {aapo_pkg::PORT_W'(hz), aapo_pkg::PORT_W'(hy), aapo_pkg::PORT_W'(hx)};
    commands_waiting = {commands_waiting, c};
  endtask

  task automatic push_scan(int idx);
    command_t c;
    c = '0;
    c.func = aapo_pkg::FUNC_SCAN;
    c.idx = aapo_pkg::IDX_W'(idx);
    // The box fields are don't-care on a scan; keep them moving anyway.
    c.en = 1'(($urandom));
    c.lo = {$urandom, $urandom, $urandom};
    c.hi = {$urandom, $urandom, $urandom};
    commands_waiting = {commands_waiting, c};
  endtask

  // Loads one body with a random box. Most boxes sit in a small cluster
  // around the origin so that pairs are common; the rest are full-range
  // noise, deliberately inverted boxes and boxes pinned to the extremes.
  task automatic push_random_load(int idx);
    int lo [3];
    int hi [3];
    int ctr;
    int half;
    int flavor;
    bit en;
    en = ($urandom_range(0, 9) < 8);
    flavor = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      ctr  = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      half = int'($urandom_range(0, 1 << 18));
      lo[k] = ctr - half;
      hi[k] = ctr + half;
      if (flavor == 7) begin
        lo[k] = $urandom;
        hi[k] = $urandom;
      end else if (flavor == 8) begin
        lo[k] = ctr + half;
        hi[k] = ctr - half;
      end else if (flavor == 9) begin
        lo[k] = ($urandom_range(0, 1) != 0) ? COORD_LOW : ctr;
        hi[k] = ($urandom_range(0, 1) != 0) ? COORD_HIGH : ctr;
      end
    end
    push_load(idx, en, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // A random stretch of work for the given body count. Every body is already
  // loaded when this runs. Most of it is in-order sweeps from body zero,
  // which is how a host walks the broad phase; the rest is reloads and
  // lone scans of arbitrary bodies, including ones past the count.
  task automatic random_mix(int count, int n_items);
    int lim;
    int made;
    int stop_at;
    int pick;
    lim = (count > aapo_pkg::MAX_BODIES) ? aapo_pkg::MAX_BODIES : count;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        push_random_load($urandom_range(0, aapo_pkg::MAX_BODIES - 1));
        made++;
      end else if (pick < 5 || lim == 0) begin
        push_scan($urandom_range(0, aapo_pkg::MAX_BODIES - 1));
        made++;
      end else begin
        stop_at = $urandom_range(1, lim);
        for (int i = 0; i < stop_at; i++) begin
          // A reload in the middle of a sweep now and then.
          if ($urandom_range(0, 7) == 0) begin
            push_random_load($urandom_range(0, aapo_pkg::MAX_BODIES - 1));
            made++;
          end
          push_scan(i);
          made++;
        end
      end
    end
  endtask

  // Waits until no command is pending or in flight and no beat is due, and
  // the block has stayed that way long enough for any scan to have drained.
  task automatic settle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (commands_waiting.size() != 0 || pair_beats_due.size() != 0 ||
          start || busy || result_strobe) quiet = 0;
      else quiet++;
    end
  endtask

  // Writes the body count. Only called while the block is idle.
  task automatic set_body_count(int value);
    @(posedge clk);
    cfg_data  <= aapo_pkg::CNT_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cnt;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Six hand-made bodies: a reference cube, one that only
    // touches it on a face (inclusive test), a disabled copy of the cube, one
    // inverted on x, one spanning the whole coordinate range and a point at
    // the top corner. With a count of four the last two lie past the limit.
    set_body_count(4);
    push_load(0, 1'b1, -10 * UNIT_Q16, -10 * UNIT_Q16, -10 * UNIT_Q16,
              10 * UNIT_Q16, 10 * UNIT_Q16, 10 * UNIT_Q16);
    push_load(1, 1'b1, 10 * UNIT_Q16, 0, 0, 20 * UNIT_Q16, 20 * UNIT_Q16, 20 * UNIT_Q16);
    push_load(2, 1'b0, -10 * UNIT_Q16, -10 * UNIT_Q16, -10 * UNIT_Q16,
              10 * UNIT_Q16, 10 * UNIT_Q16, 10 * UNIT_Q16);
    push_load(3, 1'b1, 5 * UNIT_Q16, -UNIT_Q16, -UNIT_Q16, -5 * UNIT_Q16, UNIT_Q16, UNIT_Q16);
    push_load(4, 1'b1, COORD_LOW, COORD_LOW, COORD_LOW, COORD_HIGH, COORD_HIGH, COORD_HIGH);
    push_load(5, 1'b1, COORD_HIGH, COORD_HIGH, COORD_HIGH, COORD_HIGH, COORD_HIGH,
              COORD_HIGH);
    push_scan(0);
    push_scan(1);
    push_scan(2);
    push_scan(3);
    push_scan(4);
    push_scan(5);
    push_scan(0);
    settle();

    // A zero count: scans find nothing, and body zero still clears the total.
    set_body_count(0);
    push_scan(3);
    push_scan(0);
    settle();

    // All six bodies in range, scanned out of order.
    set_body_count(6);
    push_scan(5);
    push_scan(4);
    push_scan(0);
    push_scan(1);
    settle();

    // Random part. The largest count field value is clamped by the block to
    // its capacity. Every body gets loaded first, so any scan is legal from
    // here on.
    set_body_count((1 << aapo_pkg::CNT_W) - 1);
    for (int i = 0; i < aapo_pkg::MAX_BODIES; i++) push_random_load(i);
    random_mix((1 << aapo_pkg::CNT_W) - 1, 100);
    settle();

    cnt = $urandom_range(1, aapo_pkg::MAX_BODIES - 1);
    set_body_count(cnt);
    random_mix(cnt, 80);
    settle();

    set_body_count(1);
    random_mix(1, 30);
    settle();

    set_body_count(2);
    random_mix(2, 30);
    settle();

    // Running total overflow: every body the same enabled all-space box, so
    // each scan of body one finds thirty pairs and the total pins at its
    // ceiling. Scanning body zero at the end restarts it.
    set_body_count(aapo_pkg::MAX_BODIES);
    for (int i = 0; i < aapo_pkg::MAX_BODIES; i++)
      push_load(i, 1'b1, COORD_LOW, COORD_LOW, COORD_LOW, COORD_HIGH, COORD_HIGH,
                COORD_HIGH);
    repeat (18) push_scan(1);
    push_scan(aapo_pkg::MAX_BODIES - 1);
    push_scan(0);
    settle();

    // Closing stretch at full count with the sender running flat out.
    calm = 1'b1;
    for (int i = 0; i < aapo_pkg::MAX_BODIES; i++) push_random_load(i);
    random_mix(aapo_pkg::MAX_BODIES, 50);
    settle();

    errors += pair_beats_due.size();
    if (errors == 0) begin
      $display("aabb_all_pairs_overlap_top verification clean");
    end else begin
      $display("aabb_all_pairs_overlap_top verification failed");
    end
    $finish;
  end

endmodule
